>>> design/moving_average_with_derivative_core_defines.svh
// Assertion macros shared by the filter core.
// Each macro expands to one concurrent assertion clocked on clk and
// disabled while rst is high; synthesis builds see empty bodies.
`ifndef MOVING_AVERAGE_WITH_DERIVATIVE_CORE_DEFINES_SVH
`define MOVING_AVERAGE_WITH_DERIVATIVE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MAVD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define MAVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MAVD_ASSERT_IMPLY(lbl, ante, cons, msg)
`define MAVD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/mavd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavd_pkg
// Types, widths and helpers shared by the moving average filter modules.
// ----------------------------------------------------------------------------
package mavd_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int TIME_W    = 48;
  localparam int ELAPSED_W = 32;
  localparam int AVG_W     = 32;
  localparam int SLOPE_W   = 40;

  localparam int HIST_DEPTH       = 5;
  localparam int STENCIL_W        = 37;
  localparam int AVG_SHIFT_FINE   = 8;
  localparam int AVG_SHIFT_COARSE = 5;
  localparam int STENCIL_DEN      = 6;

  // Shared divider: signed dividend, small positive divisor.
  localparam int DIV_NW     = 42;
  localparam int DIV_DW     = 9;
  localparam int DIV_STEP   = 2;
  localparam int DIV_CYCLES = DIV_NW / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    CFG_RECORDING = 1'b0,
    CFG_MODE      = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [TIME_W-1:0]          time_ms;
    logic                       clear_history;
  } in_t;

  typedef struct packed {
    logic [ELAPSED_W-1:0]      elapsed_ms;
    logic signed [AVG_W-1:0]   smoothed_value;
    logic signed [SLOPE_W-1:0] slope;
    logic                      slope_valid;
  } out_t;

  typedef struct packed {
    logic                       clear;
    logic                       process;
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample;
    logic [ELAPSED_W-1:0]       elapsed;
  } job_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIV_NW-1:0] num;
    logic [DIV_DW-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [DIV_NW-1:0] quot;
  } div_resp_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_PREP,
    D_RUN,
    D_FIN
  } div_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_READ,
    B_UPD,
    B_DIV_AVG,
    B_WAIT_AVG,
    B_TWO,
    B_STEN,
    B_DIV_SLP,
    B_WAIT_SLP,
    B_OUT
  } back_state_t;

  localparam logic signed [DIV_NW-1:0] SAT_HI =
    {{(DIV_NW - SLOPE_W + 1){1'b0}}, {(SLOPE_W - 1){1'b1}}};
  localparam logic signed [DIV_NW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic signed [SLOPE_W-1:0] sat_slope(
    input logic signed [DIV_NW-1:0] v
  );
    logic signed [SLOPE_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SLOPE_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SLOPE_W-1:0];
    end else begin
      r = v[SLOPE_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/mavd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mavd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> design/mavd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavd_div
// Iterative signed divider, two quotient bits per cycle, rounding to nearest
// with ties away from zero.
// ----------------------------------------------------------------------------
module mavd_div (
  input  logic               clk,
  input  logic               rst,
  input  mavd_pkg::div_req_t req,
  output mavd_pkg::div_resp_t resp
);
  import mavd_pkg::*;

  div_state_t state, state_next;

  logic signed [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0]        den_r;
  logic                     neg;
  logic [DIV_NW-1:0]        work;
  logic [DIV_DW-1:0]        rem;
  logic [DIV_CNT_W-1:0]     cnt;
  logic signed [DIV_NW-1:0] quot;
  logic                     done;

  logic [DIV_NW-1:0]  mag;
  logic [DIV_NW-1:0]  work_v;
  logic [DIV_DW-1:0]  rem_v;
  logic [DIV_DW:0]    trial;

  // Rounding is folded in by adding half the divisor to the magnitude.
  assign mag = (num_r[DIV_NW-1] ? DIV_NW'(-num_r) : DIV_NW'(num_r))
             + DIV_NW'(den_r >> 1);

  always_comb begin
    rem_v  = rem;
    work_v = work;
    trial  = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial = {rem_v, work_v[DIV_NW-1]};
      if (trial >= {1'b0, den_r}) begin
        rem_v  = DIV_DW'(trial - {1'b0, den_r});
        work_v = {work_v[DIV_NW-2:0], 1'b1};
      end else begin
        rem_v  = trial[DIV_DW-1:0];
        work_v = {work_v[DIV_NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == D_FIN);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      D_IDLE: if (req.start) state_next = D_PREP;
      D_PREP: state_next = D_RUN;
      D_RUN:  if (cnt == DIV_CNT_W'(1)) state_next = D_FIN;
      D_FIN:  state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        if (req.start) begin
          num_r <= req.num;
          den_r <= req.den;
        end
      end
      D_PREP: begin
        neg  <= num_r[DIV_NW-1];
        work <= mag;
        rem  <= '0;
        cnt  <= DIV_CNT_W'(DIV_CYCLES);
      end
      D_RUN: begin
        work <= work_v;
        rem  <= rem_v;
        cnt  <= cnt - DIV_CNT_W'(1);
      end
      D_FIN: begin
        quot <= neg ? -$signed(work) : $signed(work);
      end
      default: ;
    endcase
  end

  assign resp.busy = (state != D_IDLE);
  assign resp.done = done;
  assign resp.quot = quot;

endmodule
`default_nettype wire

>>> design/mavd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavd_front
// Holds the configuration, takes input words, tracks the run start time and
// hands classified jobs to the queue.
// ----------------------------------------------------------------------------
module mavd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mavd_pkg::in_t       in_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  mavd_pkg::cfg_reg_t  cfg_index,
  input  logic                cfg_data,
  output logic                push,
  output mavd_pkg::job_t      job,
  input  logic                q_full
);
  import mavd_pkg::*;

  logic              recording;
  logic              mode;
  logic              started;
  logic [TIME_W-1:0] start_ms;

  logic              accept;
  logic              start_now;
  logic [TIME_W-1:0] start_eff;
  logic [TIME_W-1:0] diff;
  logic [ELAPSED_W-1:0] elapsed;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  // A clear restarts the run, so this word then sets the start time.
  assign start_now = in_data.clear_history || !started;
  assign start_eff = start_now ? in_data.time_ms : start_ms;
  assign diff      = in_data.time_ms - start_eff;

  always_comb begin
    if (in_data.time_ms < start_eff) begin
      elapsed = '0;
    end else if (|diff[TIME_W-1:ELAPSED_W]) begin
      elapsed = '1;
    end else begin
      elapsed = diff[ELAPSED_W-1:0];
    end
  end

  assign push        = accept && (recording || in_data.clear_history);
  assign job.clear   = in_data.clear_history;
  assign job.process = recording;
  assign job.mode    = mode;
  assign job.sample  = in_data.sample_value;
  assign job.elapsed = elapsed;

  always_ff @(posedge clk) begin
    if (rst) begin
      recording <= 1'b0;
      mode      <= 1'b1;
      started   <= 1'b0;
      start_ms  <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_RECORDING: recording <= cfg_data;
          CFG_MODE:      mode      <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (recording) begin
          if (start_now) begin
            start_ms <= in_data.time_ms;
          end
          started <= 1'b1;
        end else if (in_data.clear_history) begin
          started <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> design/mavd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavd_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module mavd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mavd_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output mavd_pkg::job_t head,
  output logic           empty
);
  import mavd_pkg::*;

  job_t           entries [QUEUE_DEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QCW-1:0] count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == QCW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wptr + QAW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rptr + QAW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> design/mavd_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "moving_average_with_derivative_core_defines.svh"
// ----------------------------------------------------------------------------
// mavd_back
// Window ring, running sum, average history and slope, driving the output
// register. Averages and the five-point scaling share one divider.
// ----------------------------------------------------------------------------
module mavd_back #(
  parameter int WINDOW = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  mavd_pkg::job_t q_head,
  input  logic           q_empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output mavd_pkg::out_t out_data
);
  import mavd_pkg::*;

  localparam int AW = $clog2(WINDOW);
  localparam int FW = $clog2(WINDOW + 1);
  localparam int SW = $clog2(WINDOW + 2);
  localparam int TW = SAMPLE_W + $clog2(WINDOW) + 1;

  back_state_t state, state_next;

  job_t                      job;
  logic [FW-1:0]             fill;
  logic [AW-1:0]             ptr;
  logic signed [TW-1:0]      total;
  logic signed [AVG_W-1:0]   hist [HIST_DEPTH];
  logic [SW-1:0]             seen;
  logic signed [STENCIL_W-1:0] sten;
  logic signed [SLOPE_W-1:0] slope_r;
  logic                      valid_r;

  logic                      ram_re;
  logic                      ram_we;
  logic [SAMPLE_W-1:0]       ram_rdata;
  logic                      load_out;
  div_req_t                  div_req;
  div_resp_t                 div_resp;

  logic signed [TW-1:0]      old_ext;
  logic signed [TW-1:0]      total_next;
  logic [SW-1:0]             seen_inc;
  logic                      valid_new;
  logic signed [DIV_NW-1:0]  avg_num;
  logic signed [DIV_NW-1:0]  sten_scaled;
  logic signed [AVG_W:0]     d2;
  logic signed [DIV_NW-1:0]  two_prod;

  mavd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr),
    .wdata (job.sample),
    .re    (ram_re),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  mavd_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  // Once the ring is full the pointer sits on the oldest sample.
  assign old_ext    = (fill == FW'(WINDOW)) ? TW'($signed(ram_rdata)) : '0;
  assign total_next = total - old_ext + TW'(job.sample);
  assign seen_inc   = (seen <= SW'(WINDOW)) ? seen + SW'(1) : seen;
  assign valid_new  = (seen_inc > SW'(WINDOW));
  assign avg_num    = job.mode ? (DIV_NW'(total) <<< AVG_SHIFT_FINE)
                               : (DIV_NW'(total) <<< AVG_SHIFT_COARSE);
  assign sten_scaled = (DIV_NW'(sten) <<< 2) + DIV_NW'(sten);
  assign d2          = (AVG_W + 1)'(hist[0]) - (AVG_W + 1)'(hist[1]);
  assign two_prod    = (DIV_NW'(d2) <<< 4) + (DIV_NW'(d2) <<< 3) + DIV_NW'(d2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    pop           = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    load_out      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = avg_num;
    div_req.den   = DIV_DW'(fill);
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (q_head.process) state_next = B_READ;
        end
      end
      B_READ: begin
        ram_re     = 1'b1;
        state_next = B_UPD;
      end
      B_UPD: begin
        ram_we     = 1'b1;
        state_next = B_DIV_AVG;
      end
      B_DIV_AVG: begin
        div_req.start = 1'b1;
        state_next    = B_WAIT_AVG;
      end
      B_WAIT_AVG: begin
        if (div_resp.done) begin
          if (!valid_new) begin
            state_next = B_OUT;
          end else if (job.mode) begin
            state_next = B_STEN;
          end else begin
            state_next = B_TWO;
          end
        end
      end
      B_TWO: state_next = B_OUT;
      B_STEN: state_next = B_DIV_SLP;
      B_DIV_SLP: begin
        div_req.start = 1'b1;
        div_req.num   = sten_scaled;
        div_req.den   = DIV_DW'(STENCIL_DEN);
        state_next    = B_WAIT_SLP;
      end
      B_WAIT_SLP: begin
        if (div_resp.done) state_next = B_OUT;
      end
      B_OUT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Run state: window bookkeeping, sum and history.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      ptr       <= '0;
      total     <= '0;
      seen      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else begin
      if (pop && q_head.clear) begin
        fill  <= '0;
        ptr   <= '0;
        total <= '0;
        seen  <= '0;
        for (int i = 0; i < HIST_DEPTH; i++) begin
          hist[i] <= '0;
        end
      end
      if (state == B_UPD) begin
        total <= total_next;
        if (fill != FW'(WINDOW)) begin
          fill <= fill + FW'(1);
        end
        ptr <= (ptr == AW'(WINDOW - 1)) ? '0 : ptr + AW'(1);
      end
      if (state == B_WAIT_AVG && div_resp.done) begin
        hist[0] <= div_resp.quot[AVG_W-1:0];
        for (int i = 1; i < HIST_DEPTH; i++) begin
          hist[i] <= hist[i-1];
        end
        seen <= seen_inc;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_head;
    end
    if (state == B_WAIT_AVG && div_resp.done) begin
      valid_r <= valid_new;
      if (!valid_new) begin
        slope_r <= '0;
      end
    end
    if (state == B_TWO) begin
      slope_r <= sat_slope(two_prod);
    end
    if (state == B_STEN) begin
      sten <= -STENCIL_W'(hist[0]) + (STENCIL_W'(hist[1]) <<< 3)
            - (STENCIL_W'(hist[3]) <<< 3) + STENCIL_W'(hist[4]);
    end
    if (state == B_WAIT_SLP && div_resp.done) begin
      slope_r <= sat_slope(div_resp.quot);
    end
    if (load_out) begin
      out_data.elapsed_ms     <= job.elapsed;
      out_data.smoothed_value <= hist[0];
      out_data.slope          <= slope_r;
      out_data.slope_valid    <= valid_r;
    end
  end

  `MAVD_ASSERT_IMPLY(a_done_when_waiting, div_resp.done,
    (state == B_WAIT_AVG) || (state == B_WAIT_SLP), "divider finished outside a wait state")
  `MAVD_ASSERT_IMPLY(a_start_when_free, div_req.start, !div_resp.busy,
    "divider started while busy")
  `MAVD_ASSERT_NEXT(a_clear_empties, pop && q_head.clear, (fill == '0) && (seen == '0),
    "clear did not empty the window")
  `MAVD_ASSERT_IMPLY(a_slope_zero, out_valid && !out_data.slope_valid,
    out_data.slope == '0, "slope not zero while marked invalid")

endmodule
`default_nettype wire

>>> design/moving_average_with_derivative_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// moving_average_with_derivative_core
// Moving average over the last WINDOW samples with a slope estimate.
// ----------------------------------------------------------------------------
// Input words (sample, timestamp, clear flag) arrive on in_valid/in_stall and
// are taken when in_valid is high and in_stall low. Each word taken while
// recording is enabled yields one result word on out_valid/out_stall; with
// recording off a word yields nothing, though its clear flag still restarts
// the run. Configuration is written through cfg_valid/cfg_ready (always
// ready): index 0 enables recording, index 1 selects five-point (1) or
// two-point (0) slopes.
// The next word may enter while one is at work. The shared divider, two
// quotient bits per cycle over 42 bits, makes one pass for the average and
// a second for the five-point scaling, so five-point words take longer.
// Synchronous reset clears the window, history and run start, disables
// recording and selects five-point mode. When the receiver stalls, the result
// holds in the output register, a two-entry queue takes further words, and
// in_stall rises once it is full.
// ----------------------------------------------------------------------------
module moving_average_with_derivative_core #(
  parameter int WINDOW = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mavd_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mavd_pkg::out_t     out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  mavd_pkg::cfg_reg_t cfg_index,
  input  logic               cfg_data
);
  import mavd_pkg::*;

  logic push;
  job_t push_job;
  logic q_full;
  logic q_pop;
  job_t q_head;
  logic q_empty;

  mavd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .job       (push_job),
    .q_full    (q_full)
  );

  mavd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  mavd_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average and slope filter testbench
// Sends timestamped samples through the filter core in bursts, under several
// settings of recording and slope mode, while the result side stalls to a
// pattern of its own. Every result word is checked field by field against a
// behavioural model of the window, the mean history and the slope.
// ----------------------------------------------------------------------------
module tb;
  import mavd_pkg::*;

  localparam int WINDOW = 16;
  localparam int ITEM_TARGET = 950;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 600;
  localparam logic signed [SAMPLE_W-1:0] SMAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SMIN = 24'sh800000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_t      in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_t     out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_reg_t cfg_index = CFG_RECORDING;
  logic     cfg_data = 1'b0;

  moving_average_with_derivative_core #(.WINDOW(WINDOW)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Filter model state.
  bit          rec_on = 1'b0;
  bit          fine_mode = 1'b1;
  longint      win_buf [WINDOW];
  int          win_count;
  int          win_ptr;
  longint      win_sum;
  longint      mean_hist [5];
  int          means_seen;
  logic [47:0] run_t0;
  bit          run_live;

  in_t  sample_queue [$];
  out_t result_queue [$];
  int   errors = 0;
  int   cycle_count = 0;
  logic word_taken = 1'b0;
  int   gap_left = 0;
  int   burst_left = 4;
  bit   long_hold_arm = 1'b0;
  bit   long_hold_done = 1'b0;
  int   hold_left = 0;
  int   pattern_left = 0;
  int   stall_pct = 0;
  logic [47:0] ts_cursor = '0;

  task automatic restart_run();
    for (int i = 0; i < WINDOW; i++) win_buf[i] = 0;
    for (int i = 0; i < 5; i++) mean_hist[i] = 0;
    win_count = 0;
    win_ptr = 0;
    win_sum = 0;
    means_seen = 0;
    run_t0 = '0;
    run_live = 1'b0;
  endtask

  // Division rounded to nearest, ties away from zero; d is positive.
  function automatic longint round_div(longint n, longint d);
    if (n < 0) return -((-n + d / 2) / d);
    return (n + d / 2) / d;
  endfunction

  task automatic filter_sample(input in_t w);
    longint      smp;
    longint      mean;
    longint      slope;
    logic [47:0] span;
    out_t        r;
    smp = longint'($signed(w.sample_value));
    slope = 0;
    r = '0;
    if (w.clear_history) restart_run();
    if (!rec_on) return;
    if (!run_live) begin
      run_t0 = w.time_ms;
      run_live = 1'b1;
    end
    span = (w.time_ms < run_t0) ? 48'd0 : w.time_ms - run_t0;
    r.elapsed_ms = (span > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
    // Once the window is full the write position holds the oldest sample.
    if (win_count >= WINDOW) win_sum -= win_buf[win_ptr];
    else win_count++;
    win_buf[win_ptr] = smp;
    win_sum += smp;
    win_ptr = (win_ptr + 1) % WINDOW;
    mean = round_div(win_sum * (fine_mode ? 256 : 32), longint'(win_count));
    for (int i = 4; i > 0; i--) mean_hist[i] = mean_hist[i-1];
    mean_hist[0] = mean;
    if (means_seen <= WINDOW) means_seen++;
    r.slope_valid = (means_seen > WINDOW);
    if (r.slope_valid) begin
      if (fine_mode) begin
        slope = round_div((-mean_hist[0] + 8 * mean_hist[1] - 8 * mean_hist[3]
                           + mean_hist[4]) * 5, 6);
      end else begin
        slope = (mean_hist[0] - mean_hist[1]) * 25;
      end
      if (slope > 64'sd549755813887) slope = 64'sd549755813887;
      if (slope < -64'sd549755813888) slope = -64'sd549755813888;
    end
    r.smoothed_value = mean[31:0];
    r.slope = slope[39:0];
    result_queue.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < 50) $display("mismatch on %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  // Monitor: predicts on every accepted sample word and checks every result word.
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) filter_sample(in_data);
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          report_mismatch("result with none expected", out_data.elapsed_ms, '0);
        end else begin
          want = result_queue.pop_front();
          if (out_data.elapsed_ms !== want.elapsed_ms)
            report_mismatch("elapsed_ms", out_data.elapsed_ms, want.elapsed_ms);
          if (out_data.smoothed_value !== want.smoothed_value)
            report_mismatch("smoothed_value", out_data.smoothed_value, want.smoothed_value);
          if (out_data.slope !== want.slope)
            report_mismatch("slope", out_data.slope, want.slope);
          if (out_data.slope_valid !== want.slope_valid)
            report_mismatch("slope_valid", out_data.slope_valid, want.slope_valid);
        end
      end
    end
  end

  // Driver: offers queued sample words in bursts separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (word_taken) void'(sample_queue.pop_front());
      if (in_valid && !word_taken) begin
        // Stalled word stays on the bus unchanged.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= sample_queue[0];
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(7) == 0) begin
            burst_left = 60;
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(3) == 0) ? $urandom_range(20, 90)
                                                : $urandom_range(0, 4);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stall pattern, with one long hold-off to fill the core.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold_arm && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(10, 200);
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end else begin
        pattern_left--;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input bit val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RECORDING: rec_on = val;
      CFG_MODE:      fine_mode = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Ignored words give no result, so a fixed drain follows the last result.
  task automatic wait_idle();
    do @(posedge clk);
    while (sample_queue.size() != 0 || in_valid || result_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_t mk(input logic signed [SAMPLE_W-1:0] v, input logic [47:0] t,
                             input bit clr);
    in_t w;
    w.sample_value = v;
    w.time_ms = t;
    w.clear_history = clr;
    return w;
  endfunction

  function automatic in_t random_word(input bit clr);
    int r;
    logic signed [SAMPLE_W-1:0] v;
    r = $urandom_range(99);
    if (r < 2) ts_cursor = {$urandom, $urandom};
    else if (r < 5) ts_cursor = ts_cursor - $urandom_range(1, 1000);
    else if (r < 7) ts_cursor = ts_cursor + 48'h1_0000_0000;
    else ts_cursor = ts_cursor + $urandom_range(1, 250);
    r = $urandom_range(99);
    if (r < 10) v = $urandom_range(1) ? SMAX : SMIN;
    else if (r < 40) v = $signed($urandom_range(2000)) - 1000;
    else v = $urandom;
    return mk(v, ts_cursor, clr);
  endfunction

  initial begin
    int counted;
    int phase;
    int n;
    bit rec;
    restart_run();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Recording is off after reset: these words are dropped, the clear still acts.
    sample_queue.push_back(mk(24'sd5, 48'd10, 1'b0));
    sample_queue.push_back(mk(-24'sd3, 48'd20, 1'b1));
    wait_idle();

    write_reg(CFG_RECORDING, 1'b1);
    write_reg(CFG_MODE, 1'b1);
    sample_queue.push_back(mk(SMAX, 48'd0, 1'b1));
    sample_queue.push_back(mk(SMIN, 48'hFFFF_FFFF_FFFF, 1'b0));
    sample_queue.push_back(mk(SMAX, 48'h0000_FFFF_FFFF, 1'b0));
    sample_queue.push_back(mk(SMIN, 48'h0001_0000_0000, 1'b0));
    for (int i = 0; i < 14; i++)
      sample_queue.push_back(mk(i[0] ? SMIN : SMAX, 48'd100 + i, 1'b0));
    sample_queue.push_back(mk(24'sd0, 48'd200, 1'b0));
    // New run, then a timestamp that lies before its start.
    sample_queue.push_back(mk(-24'sd1, 48'd1000000, 1'b1));
    sample_queue.push_back(mk(24'sd1, 48'd999999, 1'b0));
    wait_idle();

    counted = 0;
    phase = 0;
    ts_cursor = 48'd5000;
    while (counted < ITEM_TARGET) begin
      rec = (phase % 6 != 5);
      if (phase % 3 == 0 || !rec || !rec_on) write_reg(CFG_RECORDING, rec);
      if (phase % 2 == 0 || $urandom_range(1)) write_reg(CFG_MODE, $urandom_range(1));
      // The pressure phase: the result side holds off while words keep coming.
      if (phase == 2) long_hold_arm = 1'b1;
      n = $urandom_range(20, 70);
      for (int i = 0; i < n; i++) begin
        sample_queue.push_back(random_word(rec ? ($urandom_range(99) < 3)
                                               : ($urandom_range(99) < 20)));
        if (rec) counted++;
      end
      wait_idle();
      phase++;
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
